// ===== hdl/tlag_pkg.sv =====
// ----------------------------------------------------------------------------
// tlag_pkg
// shared codes, controller states and the command and status structs
// ----------------------------------------------------------------------------
package tlag_pkg;

    localparam int AXIS_IDX_W = 3;
    localparam int BIT_IDX_W  = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [1:0] MODE_RESHAPE   = 2'd0;
    localparam logic [1:0] MODE_TRANSPOSE = 2'd1;
    localparam logic [1:0] MODE_SLICE     = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LAYOUT_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_RANK      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_RANK      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_EXTENTS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_EXTENTS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_PERMUTATION = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SLICE_STARTS     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SLICE_STEPS      = 3'd7;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_SLICE,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_START,
        OP_MUL,
        OP_DIV,
        OP_SLICE,
        OP_FINISH
    } t_op;

    typedef struct packed {
        t_op                   op;
        logic [AXIS_IDX_W-1:0] axis;
        logic [BIT_IDX_W-1:0]  bitn;
    } t_cmd;

    typedef struct packed {
        logic [1:0]            mode;
        logic [AXIS_IDX_W-1:0] tr_last;
        logic [AXIS_IDX_W-1:0] sr_last;
        logic                  ext_zero;
        logic                  out_free;
    } t_status;

endpackage

// ===== hdl/tensor_layout_address_generator_core.sv =====
// ----------------------------------------------------------------------------
// tensor_layout_address_generator_core
// walks target coordinates and gives source coordinates per item
// ----------------------------------------------------------------------------
// transpose and unused mode go straight to the result; slice walks each source
// axis bit-serially; reshape runs the serial shift-add flatten, then the
// restoring divider per source axis, skipping an axis with a zero extent
// one item in flight; the next item is taken once the result is registered
// reset (synchronous, active low) restores config defaults, zeroes the walk
// coordinate and empties the output register
// ----------------------------------------------------------------------------
module tensor_layout_address_generator_core #(
    parameter int MAX_RANK  = 4,
    parameter int AXIS_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tlag_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tlag_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_restart,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [63:0]                     o_source_position,
    output logic                            o_final_element,
    output logic                            o_slice_invalid
);

    tlag_pkg::t_cmd    w_cmd;
    tlag_pkg::t_status w_status;

    tlag_ctrl #(
        .AXIS_BITS (AXIS_BITS)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    tlag_datapath #(
        .MAX_RANK  (MAX_RANK),
        .AXIS_BITS (AXIS_BITS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_restart         (i_restart),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .i_ready           (i_ready),
        .o_valid           (o_valid),
        .o_source_position (o_source_position),
        .o_final_element   (o_final_element),
        .o_slice_invalid   (o_slice_invalid)
    );

endmodule

// ===== hdl/tlag_ctrl.sv =====
// ----------------------------------------------------------------------------
// tlag_ctrl
// sequencer: walks axes and bit positions and issues datapath commands
// ----------------------------------------------------------------------------
module tlag_ctrl #(
    parameter int AXIS_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  tlag_pkg::t_status i_status,
    output tlag_pkg::t_cmd    o_cmd
);

    localparam logic [tlag_pkg::BIT_IDX_W-1:0] BIT_TOP = tlag_pkg::BIT_IDX_W'(AXIS_BITS - 1);
    localparam logic [tlag_pkg::BIT_IDX_W-1:0] DIV_TOP = tlag_pkg::BIT_IDX_W'(63);

    tlag_pkg::t_state                r_state, n_state;
    logic [tlag_pkg::AXIS_IDX_W-1:0] r_axis, n_axis;
    logic [tlag_pkg::BIT_IDX_W-1:0]  r_bit, n_bit;
    logic                            w_accept;

    assign o_ready  = (r_state == tlag_pkg::S_IDLE);
    assign w_accept = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        n_axis  = r_axis;
        n_bit   = r_bit;
        case (r_state)
            tlag_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_axis = '0;
                    n_bit  = BIT_TOP;
                    case (i_status.mode)
                        tlag_pkg::MODE_RESHAPE: n_state = tlag_pkg::S_MUL;
                        tlag_pkg::MODE_SLICE:   n_state = tlag_pkg::S_SLICE;
                        default:                n_state = tlag_pkg::S_DONE;
                    endcase
                end
            end
            tlag_pkg::S_MUL: begin
                if (r_bit != '0) begin
                    n_bit = r_bit - 1'b1;
                end else if (r_axis == i_status.tr_last) begin
                    // flat index ready, split it from the last source axis down
                    n_state = tlag_pkg::S_DIV;
                    n_axis  = i_status.sr_last;
                    n_bit   = DIV_TOP;
                end else begin
                    n_axis = r_axis + 1'b1;
                    n_bit  = BIT_TOP;
                end
            end
            tlag_pkg::S_DIV: begin
                if (i_status.ext_zero || r_bit == '0) begin
                    if (r_axis == '0) begin
                        n_state = tlag_pkg::S_DONE;
                    end else begin
                        n_axis = r_axis - 1'b1;
                        n_bit  = DIV_TOP;
                    end
                end else begin
                    n_bit = r_bit - 1'b1;
                end
            end
            tlag_pkg::S_SLICE: begin
                if (r_bit != '0) begin
                    n_bit = r_bit - 1'b1;
                end else if (r_axis == i_status.sr_last) begin
                    n_state = tlag_pkg::S_DONE;
                end else begin
                    n_axis = r_axis + 1'b1;
                    n_bit  = BIT_TOP;
                end
            end
            tlag_pkg::S_DONE: begin
                if (i_status.out_free) begin
                    n_state = tlag_pkg::S_IDLE;
                end
            end
            default: n_state = tlag_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.axis = r_axis;
        o_cmd.bitn = r_bit;
        case (r_state)
            tlag_pkg::S_IDLE:  o_cmd.op = i_valid ? tlag_pkg::OP_START : tlag_pkg::OP_NONE;
            tlag_pkg::S_MUL:   o_cmd.op = tlag_pkg::OP_MUL;
            tlag_pkg::S_DIV:   o_cmd.op = tlag_pkg::OP_DIV;
            tlag_pkg::S_SLICE: o_cmd.op = tlag_pkg::OP_SLICE;
            tlag_pkg::S_DONE:  o_cmd.op = i_status.out_free ? tlag_pkg::OP_FINISH
                                                            : tlag_pkg::OP_NONE;
            default:           o_cmd.op = tlag_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tlag_pkg::S_IDLE;
            r_axis  <= '0;
            r_bit   <= '0;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
            r_bit   <= n_bit;
        end
    end

`ifndef SYNTHESIS
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state != tlag_pkg::S_IDLE)
        else $error("accepted item did not start work");
    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tlag_pkg::S_DONE && !i_status.out_free) |=> r_state == tlag_pkg::S_DONE)
        else $error("result dropped while output busy");
    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tlag_pkg::S_MUL || r_state == tlag_pkg::S_SLICE) |-> r_bit <= BIT_TOP)
        else $error("bit counter beyond axis width");
`endif

endmodule

// ===== hdl/tlag_datapath.sv =====
// ----------------------------------------------------------------------------
// tlag_datapath
// config registers, walk coordinate, serial multiply and divide, output item
// ----------------------------------------------------------------------------
module tlag_datapath #(
    parameter int MAX_RANK  = 4,
    parameter int AXIS_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tlag_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tlag_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_restart,
    input  tlag_pkg::t_cmd                  i_cmd,
    output tlag_pkg::t_status               o_status,
    input  logic                            i_ready,
    output logic                            o_valid,
    output logic [63:0]                     o_source_position,
    output logic                            o_final_element,
    output logic                            o_slice_invalid
);

    localparam int AB  = AXIS_BITS;
    localparam int AXW = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
    localparam int BW  = $clog2(AB);
    localparam int PW  = MAX_RANK * AB + 64;
    localparam logic [tlag_pkg::AXIS_IDX_W-1:0] LAST_AX = tlag_pkg::AXIS_IDX_W'(MAX_RANK - 1);

    logic [1:0]  r_mode;
    logic [2:0]  r_srank, r_trank;
    logic [63:0] r_sext, r_text, r_starts, r_steps;
    logic [7:0]  r_perm;

    logic [AB-1:0]   r_tpos [MAX_RANK];
    logic [AB-1:0]   n_tpos [MAX_RANK];
    logic [AB-1:0]   r_src  [MAX_RANK];
    logic [AB-1:0]   n_src  [MAX_RANK];
    logic [63:0]     r_flat, n_flat, r_acc, n_acc;
    logic [AB-1:0]   r_rem, n_rem;
    logic [2*AB-1:0] r_prod, n_prod;
    logic            r_invalid, n_invalid;
    logic            r_ovalid, n_ovalid;
    logic [63:0]     r_opos, n_opos;
    logic            r_ofinal, n_ofinal, r_oinv, n_oinv;

    logic [AB-1:0] sext_f [MAX_RANK];
    logic [AB-1:0] text_f [MAX_RANK];
    logic [AB-1:0] start_f [MAX_RANK];
    logic [AB-1:0] step_f [MAX_RANK];

    // packed fields that start at or beyond bit 64 read as zero
    for (genvar k = 0; k < MAX_RANK; k++) begin : g_unpack
        localparam int SH = k * AB;
        if (SH < 64) begin : g_in
            logic [63+AB:0] w_s, w_t, w_a, w_p;
            assign w_s = {{AB{1'b0}}, r_sext};
            assign w_t = {{AB{1'b0}}, r_text};
            assign w_a = {{AB{1'b0}}, r_starts};
            assign w_p = {{AB{1'b0}}, r_steps};
            assign sext_f[k]  = w_s[SH +: AB];
            assign text_f[k]  = w_t[SH +: AB];
            assign start_f[k] = w_a[SH +: AB];
            assign step_f[k]  = w_p[SH +: AB];
        end else begin : g_out
            assign sext_f[k]  = '0;
            assign text_f[k]  = '0;
            assign start_f[k] = '0;
            assign step_f[k]  = '0;
        end
    end

    logic [tlag_pkg::AXIS_IDX_W-1:0] tr_last, sr_last;

    always_comb begin
        if (r_trank == '0) tr_last = '0;
        else if (32'(r_trank) > MAX_RANK) tr_last = LAST_AX;
        else tr_last = r_trank - 1'b1;
        if (r_srank == '0) sr_last = '0;
        else if (32'(r_srank) > MAX_RANK) sr_last = LAST_AX;
        else sr_last = r_srank - 1'b1;
    end

    logic [AXW-1:0] ax;
    logic [BW-1:0]  bi;
    logic           last_bit;
    logic [AB-1:0]  e_s, e_t, st, sp, tp;

    assign ax       = i_cmd.axis[AXW-1:0];
    assign bi       = i_cmd.bitn[BW-1:0];
    assign last_bit = (i_cmd.bitn == '0);
    assign e_s      = sext_f[ax];
    assign e_t      = text_f[ax];
    assign st       = start_f[ax];
    assign sp       = step_f[ax];
    assign tp       = r_tpos[ax];

    assign o_status.mode     = r_mode;
    assign o_status.tr_last  = tr_last;
    assign o_status.sr_last  = sr_last;
    assign o_status.ext_zero = (e_s == '0);
    assign o_status.out_free = !r_ovalid || i_ready;

    // flatten step: acc = 2*acc + (extent bit ? flat : 0)
    logic [63:0] mul_acc;
    assign mul_acc = {r_acc[62:0], 1'b0} + (e_t[i_cmd.bitn[BW-1:0]] ? r_flat : 64'd0);

    // restoring division step, flat shifts out msb first and takes quotient bits
    logic [AB:0] div_sh, div_rem;
    logic        div_ge;
    assign div_sh  = {r_rem, r_flat[63]};
    assign div_ge  = div_sh >= {1'b0, e_s};
    assign div_rem = div_ge ? div_sh - {1'b0, e_s} : div_sh;

    // slice: coordinate times step, and last offset times step magnitude
    logic [AB-1:0]   sl_v, sl_mag, sl_coord, sl_n, sl_acc, sl_lim;
    logic            sl_neg, sl_bad;
    logic [2*AB-1:0] sl_prod;

    always_comb begin
        sl_v     = (e_t <= AB'(1)) ? '0 : sp;
        sl_neg   = sl_v[AB-1];
        sl_mag   = sl_neg ? (~sl_v + 1'b1) : sl_v;
        sl_coord = (i_cmd.axis <= tr_last) ? tp : '0;
        sl_n     = e_t - 1'b1;
        sl_acc   = {r_acc[AB-2:0], 1'b0} + (sl_v[bi] ? sl_coord : '0);
        sl_prod  = {r_prod[2*AB-2:0], 1'b0} + (sl_mag[bi] ? {{AB{1'b0}}, sl_n} : '0);
        sl_lim   = sl_neg ? st : (e_s - 1'b1 - st);
        sl_bad   = (st >= e_s) ||
                   ((e_t > AB'(1)) && ((sl_mag == '0) || (sl_prod > {{AB{1'b0}}, sl_lim})));
    end

    // transpose scatter, later target axes win on a repeated source axis
    logic [15:0]   perm_w;
    logic [AB-1:0] trans [MAX_RANK];
    assign perm_w = {8'd0, r_perm};

    always_comb begin
        for (int k = 0; k < MAX_RANK; k++) begin
            trans[k] = '0;
            for (int j = 0; j < MAX_RANK; j++) begin
                if ((tlag_pkg::AXIS_IDX_W'(j) <= tr_last) &&
                    ({1'b0, perm_w[2*j +: 2]} == tlag_pkg::AXIS_IDX_W'(k)) &&
                    (tlag_pkg::AXIS_IDX_W'(k) <= sr_last)) begin
                    trans[k] = r_tpos[j];
                end
            end
        end
    end

    // odometer advance, last axis fastest
    logic [AB-1:0] walk [MAX_RANK];
    logic          walk_carry;

    always_comb begin
        logic [AB:0] inc;
        walk_carry = 1'b1;
        for (int j = MAX_RANK - 1; j >= 0; j--) begin
            walk[j] = r_tpos[j];
            inc     = {1'b0, r_tpos[j]} + 1'b1;
            if ((tlag_pkg::AXIS_IDX_W'(j) <= tr_last) && walk_carry) begin
                if (inc < {1'b0, text_f[j]}) begin
                    walk[j]    = inc[AB-1:0];
                    walk_carry = 1'b0;
                end else begin
                    walk[j] = '0;
                end
            end
        end
    end

    logic [PW-1:0] pk;

    always_comb begin
        pk = '0;
        for (int k = 0; k < MAX_RANK; k++) begin
            case (r_mode)
                tlag_pkg::MODE_RESHAPE, tlag_pkg::MODE_SLICE: pk[k*AB +: AB] = r_src[k];
                tlag_pkg::MODE_TRANSPOSE:                     pk[k*AB +: AB] = trans[k];
                default:                                      pk[k*AB +: AB] = '0;
            endcase
        end
    end

    always_comb begin
        n_tpos    = r_tpos;
        n_src     = r_src;
        n_flat    = r_flat;
        n_acc     = r_acc;
        n_rem     = r_rem;
        n_prod    = r_prod;
        n_invalid = r_invalid;
        n_opos    = r_opos;
        n_ofinal  = r_ofinal;
        n_oinv    = r_oinv;
        n_ovalid  = (r_ovalid && i_ready) ? 1'b0 : r_ovalid;
        case (i_cmd.op)
            tlag_pkg::OP_START: begin
                if (i_restart) begin
                    for (int j = 0; j < MAX_RANK; j++) n_tpos[j] = '0;
                end
                for (int j = 0; j < MAX_RANK; j++) n_src[j] = '0;
                n_flat    = '0;
                n_acc     = '0;
                n_rem     = '0;
                n_prod    = '0;
                n_invalid = 1'b0;
            end
            tlag_pkg::OP_MUL: begin
                n_acc = mul_acc;
                if (last_bit) begin
                    n_flat = mul_acc + 64'(tp);
                    n_acc  = '0;
                end
            end
            tlag_pkg::OP_DIV: begin
                // a zero extent leaves the axis at zero and the flat index whole
                if (e_s != '0) begin
                    n_rem  = div_rem[AB-1:0];
                    n_flat = {r_flat[62:0], div_ge};
                    if (last_bit) begin
                        n_src[ax] = div_rem[AB-1:0];
                        n_rem     = '0;
                    end
                end
            end
            tlag_pkg::OP_SLICE: begin
                n_acc  = 64'(sl_acc);
                n_prod = sl_prod;
                if (last_bit) begin
                    n_src[ax] = st + sl_acc;
                    n_invalid = r_invalid || sl_bad;
                    n_acc     = '0;
                    n_prod    = '0;
                end
            end
            tlag_pkg::OP_FINISH: begin
                n_tpos   = walk;
                n_opos   = pk[63:0];
                n_ofinal = walk_carry;
                n_oinv   = (r_mode == tlag_pkg::MODE_SLICE) && r_invalid;
                n_ovalid = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= tlag_pkg::MODE_RESHAPE;
            r_srank  <= 3'd1;
            r_trank  <= 3'd1;
            r_sext   <= '0;
            r_text   <= '0;
            r_perm   <= '0;
            r_starts <= '0;
            r_steps  <= '0;
            r_ovalid <= 1'b0;
            for (int j = 0; j < MAX_RANK; j++) r_tpos[j] <= '0;
        end else begin
            r_ovalid <= n_ovalid;
            r_tpos   <= n_tpos;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    tlag_pkg::CFG_LAYOUT_MODE:      r_mode   <= i_cfg_data[1:0];
                    tlag_pkg::CFG_SOURCE_RANK:      r_srank  <= i_cfg_data[2:0];
                    tlag_pkg::CFG_TARGET_RANK:      r_trank  <= i_cfg_data[2:0];
                    tlag_pkg::CFG_SOURCE_EXTENTS:   r_sext   <= i_cfg_data;
                    tlag_pkg::CFG_TARGET_EXTENTS:   r_text   <= i_cfg_data;
                    tlag_pkg::CFG_AXIS_PERMUTATION: r_perm   <= i_cfg_data[7:0];
                    tlag_pkg::CFG_SLICE_STARTS:     r_starts <= i_cfg_data;
                    tlag_pkg::CFG_SLICE_STEPS:      r_steps  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_src     <= n_src;
        r_flat    <= n_flat;
        r_acc     <= n_acc;
        r_rem     <= n_rem;
        r_prod    <= n_prod;
        r_invalid <= n_invalid;
        r_opos    <= n_opos;
        r_ofinal  <= n_ofinal;
        r_oinv    <= n_oinv;
    end

    assign o_valid           = r_ovalid;
    assign o_source_position = r_opos;
    assign o_final_element   = r_ofinal;
    assign o_slice_invalid   = r_oinv;

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// drives walk steps into the tensor layout address generator under reshape,
// transpose, slice and unused modes, predicts each source coordinate and
// checks it against the result items, with random gaps on both sides
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [tlag_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [tlag_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic        i_restart;
    logic        o_valid;
    logic        i_ready;
    logic [63:0] o_source_position;
    logic        o_final_element;
    logic        o_slice_invalid;

    tensor_layout_address_generator_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready), .i_restart(i_restart),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_source_position(o_source_position),
        .o_final_element(o_final_element),
        .o_slice_invalid(o_slice_invalid)
    );

    typedef struct packed {
        logic [63:0] pos;
        logic        fin;
        logic        inv;
    } t_addr;

    // predictor copy of the configuration and walk coordinate
    logic [1:0]  m_mode;
    logic [2:0]  m_srank, m_trank;
    logic [63:0] m_sext, m_text, m_starts, m_steps;
    logic [7:0]  m_perm;
    logic [15:0] m_coord [4];

    logic   step_q [$];
    t_addr  addr_q [$];
    int     errors;
    int     mismatches;
    int     idle_cycles;
    int     send_gap;
    int     recv_gap;
    int     recv_draw;
    bit     hold_send;

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int eff_rank(logic [2:0] r);
        if (r == 0) return 1;
        if (r > 4) return 4;
        return int'(r);
    endfunction

    function automatic logic [15:0] fld(logic [63:0] r, int k);
        return r[k*16 +: 16];
    endfunction

    task automatic predict_addr(input logic restart);
        logic [15:0] src [4];
        logic [63:0] flat, e, start, se, te, n, mag;
        logic [15:0] sv;
        logic [63:0] stepx;
        logic        neg, inv, carry;
        int sr, tr, p;
        t_addr r;
        sr = eff_rank(m_srank);
        tr = eff_rank(m_trank);
        inv = 0;
        if (restart) for (int j = 0; j < 4; j++) m_coord[j] = 0;
        for (int j = 0; j < 4; j++) src[j] = 0;
        if (m_mode == tlag_pkg::MODE_RESHAPE) begin
            flat = 0;
            for (int j = 0; j < tr; j++) flat = flat * fld(m_text, j) + m_coord[j];
            for (int j = sr; j > 0; j--) begin
                e = {48'd0, fld(m_sext, j-1)};
                if (e != 0) begin
                    src[j-1] = 16'(flat % e);
                    flat = flat / e;
                end
            end
        end else if (m_mode == tlag_pkg::MODE_TRANSPOSE) begin
            for (int j = 0; j < tr; j++) begin
                p = int'(m_perm[2*j +: 2]);
                if (p < sr) src[p] = m_coord[j];
            end
        end else if (m_mode == tlag_pkg::MODE_SLICE) begin
            for (int j = 0; j < sr; j++) begin
                start = {48'd0, fld(m_starts, j)};
                se = {48'd0, fld(m_sext, j)};
                te = {48'd0, fld(m_text, j)};
                sv = (te <= 1) ? 16'd0 : fld(m_steps, j);
                neg = sv[15];
                mag = neg ? {48'd0, 16'(-sv)} : {48'd0, sv};
                if (neg && mag == 0) mag = 64'h8000;
                stepx = {{48{sv[15]}}, sv};
                src[j] = 16'(start + ((j < tr) ? {48'd0, m_coord[j]} : 64'd0) * stepx);
                if (start >= se) inv = 1;
                else if (te > 1) begin
                    n = te - 1;
                    if (mag == 0) inv = 1;
                    else if (!neg && n > (se - 1 - start) / mag) inv = 1;
                    else if (neg && n > start / mag) inv = 1;
                end
            end
        end
        carry = 1;
        for (int j = tr; j > 0 && carry; j--) begin
            if ({1'b0, m_coord[j-1]} + 17'd1 < {1'b0, fld(m_text, j-1)}) begin
                m_coord[j-1] = m_coord[j-1] + 16'd1;
                carry = 0;
            end else m_coord[j-1] = 0;
        end
        r.pos = {src[3], src[2], src[1], src[0]};
        r.fin = carry;
        r.inv = (m_mode == tlag_pkg::MODE_SLICE) && inv;
        addr_q.push_back(r);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 0;
            send_gap <= 0;
        end else begin
            if (i_valid && o_ready) predict_addr(i_restart);
            if (!(i_valid && !o_ready)) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_valid <= 0;
                end else if (step_q.size() > 0 && !hold_send) begin
                    i_restart <= step_q.pop_front();
                    i_valid <= 1;
                    send_gap <= $urandom_range(0, 8) * ($urandom_range(0, 3) != 0);
                end else i_valid <= 0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 0;
            recv_gap <= 0;
        end else begin
            if (o_valid && i_ready) begin
                if (addr_q.size() == 0) begin
                    errors++;
                    if (mismatches++ < 10) $display("unexpected item %h", o_source_position);
                end else begin
                    t_addr x;
                    x = addr_q.pop_front();
                    if (x.pos !== o_source_position || x.fin !== o_final_element ||
                        x.inv !== o_slice_invalid) begin
                        errors++;
                        if (mismatches++ < 10)
                            $display("mismatch exp %h/%b/%b got %h/%b/%b", x.pos, x.fin,
                                     x.inv, o_source_position, o_final_element,
                                     o_slice_invalid);
                    end
                end
                recv_draw = $urandom_range(0, 8) * ($urandom_range(0, 3) != 0);
                recv_gap <= recv_draw;
                i_ready <= (recv_draw == 0);
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                i_ready <= (recv_gap == 1);
            end else i_ready <= 1;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || i_cfg_we) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("tensor_layout_address_generator_core test failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [tlag_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] d);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        case (idx)
            tlag_pkg::CFG_LAYOUT_MODE:      m_mode = d[1:0];
            tlag_pkg::CFG_SOURCE_RANK:      m_srank = d[2:0];
            tlag_pkg::CFG_TARGET_RANK:      m_trank = d[2:0];
            tlag_pkg::CFG_SOURCE_EXTENTS:   m_sext = d;
            tlag_pkg::CFG_TARGET_EXTENTS:   m_text = d;
            tlag_pkg::CFG_AXIS_PERMUTATION: m_perm = d[7:0];
            tlag_pkg::CFG_SLICE_STARTS:     m_starts = d;
            tlag_pkg::CFG_SLICE_STEPS:      m_steps = d;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 0;
        @(posedge i_clk);
    endtask

    task automatic drain;
        while (step_q.size() > 0 || i_valid || addr_q.size() > 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    function automatic logic [63:0] small_ext(int lim);
        logic [63:0] v;
        for (int k = 0; k < 4; k++) v[k*16 +: 16] = 16'($urandom_range(0, lim));
        return v;
    endfunction

    task automatic run_steps(int count);
        for (int k = 0; k < count; k++) step_q.push_back($urandom_range(0, 15) == 0);
        drain();
    endtask

    initial begin
        logic [63:0] se;
        errors = 0;
        mismatches = 0;
        idle_cycles = 0;
        hold_send = 0;
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_index = tlag_pkg::CFG_LAYOUT_MODE;
        i_cfg_data = 0;
        i_valid = 0;
        i_restart = 0;
        i_ready = 0;
        m_mode = tlag_pkg::MODE_RESHAPE;
        m_srank = 1;
        m_trank = 1;
        m_sext = 0; m_text = 0; m_perm = 0; m_starts = 0; m_steps = 0;
        for (int j = 0; j < 4; j++) m_coord[j] = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // reset defaults, then extremes of extents
        for (int k = 0; k < 3; k++) step_q.push_back(k == 2);
        drain();
        write_reg(tlag_pkg::CFG_SOURCE_RANK, 0);
        write_reg(tlag_pkg::CFG_TARGET_RANK, 7);
        write_reg(tlag_pkg::CFG_SOURCE_EXTENTS, 64'hFFFF_0000_0001_FFFF);
        write_reg(tlag_pkg::CFG_TARGET_EXTENTS, 64'hFFFF_FFFF_0001_FFFF);
        write_reg(tlag_pkg::CFG_AXIS_PERMUTATION, 8'hFF);
        write_reg(tlag_pkg::CFG_SLICE_STARTS, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(tlag_pkg::CFG_SLICE_STEPS, 64'h8000_8000_7FFF_FFFF);
        for (int md = 0; md < 4; md++) begin
            write_reg(tlag_pkg::CFG_LAYOUT_MODE, 64'(md));
            for (int k = 0; k < 5; k++) step_q.push_back(k == 0);
            drain();
        end
        // sender holds back the queued steps, then releases them
        hold_send = 1;
        for (int k = 0; k < 4; k++) step_q.push_back(0);
        repeat (60) @(posedge i_clk);
        hold_send = 0;
        drain();

        for (int ph = 0; ph < 60; ph++) begin
            write_reg(tlag_pkg::CFG_LAYOUT_MODE,
                      $urandom_range(0, 9) == 0 ? 3 : $urandom_range(0, 2));
            write_reg(tlag_pkg::CFG_SOURCE_RANK,
                      $urandom_range(0, 9) == 0 ? $urandom_range(0, 7) : $urandom_range(1, 4));
            write_reg(tlag_pkg::CFG_TARGET_RANK,
                      $urandom_range(0, 9) == 0 ? $urandom_range(0, 7) : $urandom_range(1, 4));
            se = small_ext(6);
            if ($urandom_range(0, 5) == 0) se = {$urandom, $urandom};
            write_reg(tlag_pkg::CFG_SOURCE_EXTENTS, se);
            write_reg(tlag_pkg::CFG_TARGET_EXTENTS, ($urandom_range(0, 7) == 0) ?
                      {$urandom, $urandom} : small_ext(5));
            write_reg(tlag_pkg::CFG_AXIS_PERMUTATION, 64'($urandom_range(0, 255)));
            write_reg(tlag_pkg::CFG_SLICE_STARTS, ($urandom_range(0, 3) == 0) ?
                      {$urandom, $urandom} : small_ext(4));
            write_reg(tlag_pkg::CFG_SLICE_STEPS, ($urandom_range(0, 3) == 0) ?
                      {$urandom, $urandom} : {16'($urandom_range(0, 4) - 2),
                      16'($urandom_range(0, 4) - 2), 16'($urandom_range(0, 4) - 2),
                      16'($urandom_range(0, 4) - 2)});
            run_steps(30);
        end

        if (errors == 0 && addr_q.size() == 0) begin
            $display("tensor_layout_address_generator_core test passed");
        end else begin
            $display("tensor_layout_address_generator_core test failed");
        end
        $finish;
    end
endmodule
